>>> src/tcw_pkg.sv
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_STREAM = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POKE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  // stream control codes
  localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

  localparam logic [BYTE_W-1:0] TAB_STEP = 8'd4;
  localparam logic [BYTE_W-1:0] TAB_MASK = 8'hFC;

  // space at attribute 0x07: attr in the upper byte
  localparam logic [2*BYTE_W-1:0] BLANK_CELL = 16'h0720;

  typedef struct packed {
    logic item_read;
    logic item_clear;
    logic item_scroll;
    logic sweep_last;
  } stat_t;

  typedef struct packed {
    logic accept;
    logic capture;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic              ignored;
  } res_t;

endpackage

>>> src/tcw_req_if.sv
interface tcw_req_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::KIND_W-1:0]   kind;
  logic [tcw_pkg::BYTE_W-1:0]   char_code;
  logic [tcw_pkg::BYTE_W-1:0]   attr_byte;
  logic [tcw_pkg::COL_W-1:0]    col_sel;
  logic [tcw_pkg::ROW_W-1:0]    row_sel;

  modport source (output valid, kind, char_code, attr_byte, col_sel, row_sel, input ready);
  modport sink (input valid, kind, char_code, attr_byte, col_sel, row_sel, output ready);
endinterface

>>> src/tcw_rsp_if.sv
interface tcw_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::BYTE_W-1:0]   read_char;
  logic [tcw_pkg::BYTE_W-1:0]   read_attr;
  logic [tcw_pkg::COL_W-1:0]    cursor_col;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;
  logic                         scrolled;
  logic                         ignored;

  modport source (output valid, read_char, read_attr, cursor_col, cursor_row, scrolled,
                  ignored, input ready);
  modport sink (input valid, read_char, read_attr, cursor_col, cursor_row, scrolled,
                ignored, output ready);
endinterface

>>> src/tcw_ctrl.sv
module tcw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_ready,
  input  tcw_pkg::stat_t stat,
  output logic           in_ready,
  output logic           out_valid,
  output tcw_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       load;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next  = state;
    cmd.accept  = 1'b0;
    cmd.capture = 1'b0;
    cmd.sweep   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (stat.item_clear || stat.item_scroll) begin
            state_next = ST_SWEEP;
          end else if (stat.item_read) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.capture = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  // reads load their result in the READ state after the accept, once the array data is back
  assign load           = (cmd.accept && !stat.item_read) || cmd.capture;
  assign out_valid_next = (out_valid && !out_ready) || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> src/tcw_dp.sv
module tcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tcw_pkg::cmd_t                cmd,
  input  logic [tcw_pkg::KIND_W-1:0]   kind,
  input  logic [tcw_pkg::BYTE_W-1:0]   char_code,
  input  logic [tcw_pkg::BYTE_W-1:0]   attr_byte,
  input  logic [tcw_pkg::COL_W-1:0]    col_sel,
  input  logic [tcw_pkg::ROW_W-1:0]    row_sel,
  output tcw_pkg::stat_t               stat,
  output tcw_pkg::res_t                res
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [2*tcw_pkg::BYTE_W-1:0] mem [CELLS];
  logic [2*tcw_pkg::BYTE_W-1:0] mem_q;

  logic [tcw_pkg::COL_W-1:0] cur_x;
  logic [tcw_pkg::ROW_W-1:0] cur_y;
  logic [tcw_pkg::ROW_W-1:0] base;
  logic [ADDR_W-1:0]         sweep_addr;
  logic [ADDR_W-1:0]         sweep_cnt;
  logic                      rd_ok;

  logic                      sel_ok;
  logic                      is_stream;
  logic                      printable;
  logic [tcw_pkg::BYTE_W-1:0] x_inc;
  logic [tcw_pkg::BYTE_W-1:0] x_tab;
  logic [tcw_pkg::COL_W-1:0] x_next;
  logic                      new_line;
  logic [tcw_pkg::ROW_W:0]   y_inc;
  logic [tcw_pkg::ROW_W-1:0] y_next;
  logic                      scroll;
  logic [tcw_pkg::ROW_W-1:0] base_inc;
  logic [tcw_pkg::COL_W-1:0] a_col;
  logic [tcw_pkg::ROW_W-1:0] a_row;
  logic [tcw_pkg::ROW_W:0]   phys_sum;
  logic [tcw_pkg::ROW_W-1:0] phys_row;
  logic [ADDR_W-1:0]         item_addr;
  logic                      item_we;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [2*tcw_pkg::BYTE_W-1:0] wr_data;

  assign sel_ok = ({1'b0, col_sel} < (tcw_pkg::COL_W + 1)'(COLUMNS))
               && ({1'b0, row_sel} < (tcw_pkg::ROW_W + 1)'(ROWS));
  assign is_stream = (kind == tcw_pkg::KIND_STREAM);
  assign printable = (char_code != tcw_pkg::CH_NL) && (char_code != tcw_pkg::CH_CR)
                  && (char_code != tcw_pkg::CH_BS) && (char_code != tcw_pkg::CH_TAB);

  // cursor move for a stream character
  assign x_inc = {1'b0, cur_x} + 8'd1;
  assign x_tab = ({1'b0, cur_x} + tcw_pkg::TAB_STEP) & tcw_pkg::TAB_MASK;

  always_comb begin
    x_next   = cur_x;
    new_line = 1'b0;
    case (char_code)
      tcw_pkg::CH_NL: begin
        x_next   = '0;
        new_line = 1'b1;
      end
      tcw_pkg::CH_CR: begin
        x_next = '0;
      end
      tcw_pkg::CH_BS: begin
        if (cur_x != '0) begin
          x_next = cur_x - 7'd1;
        end
      end
      tcw_pkg::CH_TAB: begin
        if (x_tab >= tcw_pkg::BYTE_W'(COLUMNS)) begin
          x_next   = '0;
          new_line = 1'b1;
        end else begin
          x_next = x_tab[tcw_pkg::COL_W-1:0];
        end
      end
      default: begin
        if (x_inc >= tcw_pkg::BYTE_W'(COLUMNS)) begin
          x_next   = '0;
          new_line = 1'b1;
        end else begin
          x_next = x_inc[tcw_pkg::COL_W-1:0];
        end
      end
    endcase
  end

  assign y_inc  = {1'b0, cur_y} + (tcw_pkg::ROW_W + 1)'(new_line);
  assign scroll = is_stream && (y_inc >= (tcw_pkg::ROW_W + 1)'(ROWS));
  assign y_next = scroll ? tcw_pkg::ROW_W'(ROWS - 1) : y_inc[tcw_pkg::ROW_W-1:0];
  assign base_inc = (base == tcw_pkg::ROW_W'(ROWS - 1)) ? '0 : base + 5'd1;

  // logical row to physical row of the ring of rows
  assign a_col    = is_stream ? cur_x : (sel_ok ? col_sel : '0);
  assign a_row    = is_stream ? cur_y : (sel_ok ? row_sel : '0);
  assign phys_sum = {1'b0, a_row} + {1'b0, base};
  assign phys_row = (phys_sum >= (tcw_pkg::ROW_W + 1)'(ROWS))
                  ? tcw_pkg::ROW_W'(phys_sum - (tcw_pkg::ROW_W + 1)'(ROWS))
                  : phys_sum[tcw_pkg::ROW_W-1:0];
  assign item_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(a_col);

  assign item_we = (is_stream && printable) || ((kind == tcw_pkg::KIND_POKE) && sel_ok);
  assign wr_en   = cmd.sweep || (cmd.accept && item_we);
  assign wr_addr = cmd.sweep ? sweep_addr : item_addr;
  assign wr_data = cmd.sweep ? tcw_pkg::BLANK_CELL : {attr_byte, char_code};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[item_addr];
  end

  assign stat.item_read   = (kind == tcw_pkg::KIND_READ);
  assign stat.item_clear  = (kind == tcw_pkg::KIND_CLEAR);
  assign stat.item_scroll = scroll;
  assign stat.sweep_last  = (sweep_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      base       <= '0;
      sweep_addr <= '0;
      sweep_cnt  <= ADDR_W'(CELLS - 1);
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_addr + 1'b1;
      sweep_cnt  <= sweep_cnt - 1'b1;
    end else if (cmd.accept) begin
      if (kind == tcw_pkg::KIND_CLEAR) begin
        cur_x      <= '0;
        cur_y      <= '0;
        base       <= '0;
        sweep_addr <= '0;
        sweep_cnt  <= ADDR_W'(CELLS - 1);
      end else if (is_stream) begin
        cur_x <= x_next;
        cur_y <= y_next;
        if (scroll) begin
          // old top row becomes the blank bottom row
          base       <= base_inc;
          sweep_addr <= ADDR_W'(base) * ADDR_W'(COLUMNS);
          sweep_cnt  <= ADDR_W'(COLUMNS - 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_ok          <= sel_ok;
      res.read_char  <= '0;
      res.read_attr  <= '0;
      res.scrolled   <= scroll;
      res.ignored    <= !sel_ok && (kind == tcw_pkg::KIND_POKE
                                    || kind == tcw_pkg::KIND_READ);
      case (kind)
        tcw_pkg::KIND_STREAM: begin
          res.cursor_col <= x_next;
          res.cursor_row <= y_next;
        end
        tcw_pkg::KIND_CLEAR: begin
          res.cursor_col <= '0;
          res.cursor_row <= '0;
        end
        default: begin
          res.cursor_col <= cur_x;
          res.cursor_row <= cur_y;
        end
      endcase
    end else if (cmd.capture && rd_ok) begin
      res.read_char <= mem_q[tcw_pkg::BYTE_W-1:0];
      res.read_attr <= mem_q[2*tcw_pkg::BYTE_W-1:tcw_pkg::BYTE_W];
    end
  end

endmodule

>>> src/text_console_cell_writer.sv
// Text console cell writer: a COLUMNS x ROWS grid of 16-bit cells (char in
// the low byte, attribute in the high byte) plus a cursor, fed by a request
// stream of four kinds: stream character, poke cell, clear screen and read
// cell. Every request returns exactly one response with the cursor after it.
// Flow: stream characters and pokes can follow back to back while the
// response side keeps up. A read waits on the registered read port of the
// cell array. A stream character that scrolls is followed by a refill, as
// the grid is kept as a ring of rows (a base row pointer moves, no rows are
// copied) and only the new bottom row is blanked, one cell a cycle. Clear
// screen blanks all COLUMNS*ROWS cells. After reset the array is blanked by
// a pass over all COLUMNS*ROWS cells (2000 at the default size) during
// which no request is taken. The response of a scroll or clear is offered
// at once; the next request waits for the refill.
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp
);

  tcw_pkg::stat_t stat;
  tcw_pkg::cmd_t  cmd;
  tcw_pkg::res_t  res;

  // controller: sequencing, handshakes, refill sweeps
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .cmd       (cmd)
  );

  // datapath: cursor, row ring pointer, cell array, response register
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .kind      (req.kind),
    .char_code (req.char_code),
    .attr_byte (req.attr_byte),
    .col_sel   (req.col_sel),
    .row_sel   (req.row_sel),
    .stat      (stat),
    .res       (res)
  );

  assign rsp.read_char  = res.read_char;
  assign rsp.read_attr  = res.read_attr;
  assign rsp.cursor_col = res.cursor_col;
  assign rsp.cursor_row = res.cursor_row;
  assign rsp.scrolled   = res.scrolled;
  assign rsp.ignored    = res.ignored;

endmodule
